// ----- sv/mtp_pkg.sv -----
// ---------------------------------------------------------------------------
// mtp_pkg
// Types, constants and helper functions for the MT19937 generator.
// ---------------------------------------------------------------------------
package mtp_pkg;

    localparam int STATE_WORDS = 624;
    localparam int SW_AW       = 10;
    localparam int SHIFT_M     = 397;

    localparam logic [SW_AW-1:0] LAST_POS  = SW_AW'(STATE_WORDS - 1);
    localparam logic [SW_AW-1:0] ALL_USED  = SW_AW'(STATE_WORDS);
    localparam logic [SW_AW-1:0] FAR_SPLIT = SW_AW'(STATE_WORDS - SHIFT_M);

    localparam logic [31:0] TWIST_A   = 32'h9908_b0df;
    localparam logic [31:0] HIGH_BIT  = 32'h8000_0000;
    localparam logic [31:0] LOW_BITS  = 32'h7fff_ffff;
    localparam logic [31:0] C_FILL    = 32'd1812433253;
    localparam logic [31:0] C_MIX1    = 32'd1664525;
    localparam logic [31:0] C_MIX2    = 32'd1566083941;
    localparam logic [31:0] MIX_SEED  = 32'd19650218;
    localparam logic [31:0] DFLT_SEED = 32'd5489;
    localparam logic [31:0] TEMPER_B  = 32'h9d2c_5680;
    localparam logic [31:0] TEMPER_C  = 32'hefc6_0000;

    localparam logic [1:0] MODE_SEED = 2'd0;
    localparam logic [1:0] MODE_KEY  = 2'd1;
    localparam logic [1:0] MODE_DRAW = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FILL0,
        S_FILL_A,
        S_FILL_B,
        S_MIX_A,
        S_MIX_B,
        S_MIX_WRAP,
        S_MIX_END,
        S_TW_START,
        S_TW_LD,
        S_TW_A,
        S_TW_B,
        S_DRAW_RD,
        S_DRAW_OUT
    } mtp_state_t;

    typedef enum logic [1:0] {
        AFTER_NONE,
        AFTER_MIX,
        AFTER_TWIST
    } mtp_ctx_t;

    function automatic logic [31:0] mtp_fold(input logic [31:0] p);
        mtp_fold = p ^ (p >> 30);
    endfunction

    function automatic logic [31:0] mtp_twist(input logic [31:0] cur,
                                              input logic [31:0] nxt,
                                              input logic [31:0] far);
        logic [31:0] y;
        y = (cur & HIGH_BIT) | (nxt & LOW_BITS);
        mtp_twist = far ^ (y >> 1) ^ (y[0] ? TWIST_A : 32'd0);
    endfunction

    function automatic logic [31:0] mtp_temper(input logic [31:0] w);
        logic [31:0] y;
        y = w ^ (w >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        mtp_temper = y ^ (y >> 18);
    endfunction

endpackage

// ----- sv/mtp_ram.sv -----
// ---------------------------------------------------------------------------
// mtp_ram
// Simple dual-port memory: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module mtp_ram #(
    parameter int DEPTH = 624,
    parameter int WIDTH = 32
) (
    input  logic                                    clk,
    input  logic                                    wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- sv/mersenne_twister_prng.sv -----
// ---------------------------------------------------------------------------
// mersenne_twister_prng
// MT19937 generator: seeding, init-by-array key mixing and tempered draws.
// ---------------------------------------------------------------------------
// The 624-word state sits in two mirrored memories (two read ports, one
// shared write) and is updated by a sequencer with one 32x32 constant
// multiplier. One item is worked at a time. A seed beat fills the state with
// a multiply then a write for each state word. A key beat is stored while
// the key store has room, and the final key beat runs a seed fill, then 624
// and 623 mixing steps, each a multiply then a write. A draw reads a state
// word and tempers it into the output register; every 624th draw first runs
// a twist (per word: read next and far words, then write), preceded by a
// default seed fill if no seed was given. Results wait in an output register
// while new beats are taken.
// ---------------------------------------------------------------------------
module mersenne_twister_prng #(
    parameter int KEY_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [31:0] word,
    input  logic        key_last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] random_word
);

    import mtp_pkg::*;

    localparam int KAW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
    localparam int KCW = $clog2(KEY_DEPTH + 1);
    localparam logic [KCW-1:0] KEY_FULL = KCW'(KEY_DEPTH);

    mtp_state_t state_reg, state_next;
    mtp_ctx_t   ctx_reg, ctx_next;

    logic             seeded_reg, seeded_next;
    logic [SW_AW-1:0] idx_reg, idx_next;
    logic [KCW-1:0]   key_count_reg, key_count_next;
    logic [KCW-1:0]   len_reg, len_next;
    logic [KAW-1:0]   b_reg, b_next;
    logic [SW_AW-1:0] n_reg, n_next;
    logic [SW_AW-1:0] left_reg, left_next;
    logic             pass2_reg, pass2_next;
    logic [31:0]      p_reg, p_next;
    logic [31:0]      prod_reg, prod_next;
    logic [31:0]      cur_reg, cur_next;
    logic [31:0]      seed_reg, seed_next;
    logic             out_valid_reg, out_valid_next;
    logic [31:0]      out_word_reg, out_word_next;

    logic             st_wr_en;
    logic [SW_AW-1:0] st_wr_addr;
    logic [31:0]      st_wr_data;
    logic [SW_AW-1:0] rd_a_addr, rd_b_addr;
    logic [31:0]      rd_a_data, rd_b_data;

    logic             key_wr_en;
    logic [KAW-1:0]   key_wr_addr;
    logic [KAW-1:0]   key_rd_addr;
    logic [31:0]      key_rd_data;

    logic             in_beat;
    logic             out_free;
    logic [31:0]      mult_const;
    logic [31:0]      mult_out;
    logic [31:0]      mix_val;
    logic [KCW-1:0]   b_inc;

    mtp_ram #(.DEPTH(STATE_WORDS), .WIDTH(32)) u_state_a (
        .clk     (clk),
        .wr_en   (st_wr_en),
        .wr_addr (st_wr_addr),
        .wr_data (st_wr_data),
        .rd_addr (rd_a_addr),
        .rd_data (rd_a_data)
    );

    mtp_ram #(.DEPTH(STATE_WORDS), .WIDTH(32)) u_state_b (
        .clk     (clk),
        .wr_en   (st_wr_en),
        .wr_addr (st_wr_addr),
        .wr_data (st_wr_data),
        .rd_addr (rd_b_addr),
        .rd_data (rd_b_data)
    );

    mtp_ram #(.DEPTH(KEY_DEPTH), .WIDTH(32)) u_key (
        .clk     (clk),
        .wr_en   (key_wr_en),
        .wr_addr (key_wr_addr),
        .wr_data (word),
        .rd_addr (key_rd_addr),
        .rd_data (key_rd_data)
    );

    assign in_ready    = (state_reg == S_IDLE);
    assign in_beat     = in_valid && in_ready;
    assign out_valid   = out_valid_reg;
    assign random_word = out_word_reg;
    assign out_free    = !out_valid_reg || out_ready;

    assign mult_const = (state_reg == S_FILL_A) ? C_FILL : (pass2_reg ? C_MIX2 : C_MIX1);
    assign mult_out   = mtp_fold(p_reg) * mult_const;
    assign b_inc      = KCW'(b_reg) + KCW'(1);
    assign mix_val    = pass2_reg ? ((rd_a_data ^ prod_reg) - {22'd0, n_reg})
                                  : ((rd_a_data ^ prod_reg) + key_rd_data + 32'(b_reg));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_beat)
                begin
                    case (mode)
                        MODE_SEED: state_next = S_FILL0;
                        MODE_KEY:  state_next = key_last ? S_FILL0 : S_IDLE;
                        MODE_DRAW:
                        begin
                            if (idx_reg >= ALL_USED)
                                state_next = seeded_reg ? S_TW_START : S_FILL0;
                            else
                                state_next = S_DRAW_RD;
                        end
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_FILL0:  state_next = S_FILL_A;
            S_FILL_A: state_next = S_FILL_B;
            S_FILL_B:
            begin
                if (n_reg == LAST_POS)
                begin
                    case (ctx_reg)
                        AFTER_MIX:   state_next = S_MIX_A;
                        AFTER_TWIST: state_next = S_TW_START;
                        default:     state_next = S_IDLE;
                    endcase
                end
                else
                begin
                    state_next = S_FILL_A;
                end
            end
            S_MIX_A: state_next = S_MIX_B;
            S_MIX_B:
            begin
                if (n_reg == LAST_POS)
                    state_next = S_MIX_WRAP;
                else if (pass2_reg && left_reg == SW_AW'(1))
                    state_next = S_MIX_END;
                else
                    state_next = S_MIX_A;
            end
            S_MIX_WRAP: state_next = (pass2_reg && left_reg == '0) ? S_MIX_END : S_MIX_A;
            S_MIX_END:  state_next = S_IDLE;
            S_TW_START: state_next = S_TW_LD;
            S_TW_LD:    state_next = S_TW_A;
            S_TW_A:     state_next = S_TW_B;
            S_TW_B:     state_next = (n_reg == LAST_POS) ? S_DRAW_RD : S_TW_A;
            S_DRAW_RD:  state_next = S_DRAW_OUT;
            S_DRAW_OUT: state_next = out_free ? S_IDLE : S_DRAW_OUT;
            default:    state_next = S_IDLE;
        endcase
    end

    // datapath and memory ports
    always_comb
    begin
        ctx_next       = ctx_reg;
        seeded_next    = seeded_reg;
        idx_next       = idx_reg;
        key_count_next = key_count_reg;
        len_next       = len_reg;
        b_next         = b_reg;
        n_next         = n_reg;
        left_next      = left_reg;
        pass2_next     = pass2_reg;
        p_next         = p_reg;
        prod_next      = prod_reg;
        cur_next       = cur_reg;
        seed_next      = seed_reg;
        out_word_next  = out_word_reg;
        out_valid_next = out_valid_reg && !out_ready;

        st_wr_en    = 1'b0;
        st_wr_addr  = n_reg;
        st_wr_data  = mix_val;
        rd_a_addr   = n_reg;
        rd_b_addr   = n_reg;
        key_wr_en   = 1'b0;
        key_wr_addr = key_count_reg[KAW-1:0];
        key_rd_addr = b_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_beat)
                begin
                    case (mode)
                        MODE_SEED:
                        begin
                            seed_next = word;
                            ctx_next  = AFTER_NONE;
                        end
                        MODE_KEY:
                        begin
                            if (key_count_reg < KEY_FULL)
                            begin
                                key_wr_en      = 1'b1;
                                key_count_next = key_count_reg + KCW'(1);
                            end
                            if (key_last)
                            begin
                                len_next       = (key_count_reg < KEY_FULL)
                                                 ? key_count_reg + KCW'(1) : key_count_reg;
                                key_count_next = '0;
                                seed_next      = MIX_SEED;
                                ctx_next       = AFTER_MIX;
                            end
                        end
                        MODE_DRAW:
                        begin
                            if (idx_reg >= ALL_USED && !seeded_reg)
                            begin
                                seed_next = DFLT_SEED;
                                ctx_next  = AFTER_TWIST;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_FILL0:
            begin
                st_wr_en   = 1'b1;
                st_wr_addr = '0;
                st_wr_data = seed_reg;
                p_next     = seed_reg;
                n_next     = SW_AW'(1);
            end
            S_FILL_A:
            begin
                prod_next = mult_out;
            end
            S_FILL_B:
            begin
                st_wr_en   = 1'b1;
                st_wr_data = prod_reg + {22'd0, n_reg};
                p_next     = prod_reg + {22'd0, n_reg};
                if (n_reg == LAST_POS)
                begin
                    idx_next    = ALL_USED;
                    seeded_next = 1'b1;
                    // mixing starts from word 0, which still holds the seed
                    p_next      = seed_reg;
                    n_next      = SW_AW'(1);
                    b_next      = '0;
                    left_next   = ALL_USED;
                    pass2_next  = 1'b0;
                end
                else
                begin
                    n_next = n_reg + SW_AW'(1);
                end
            end
            S_MIX_A:
            begin
                prod_next = mult_out;
            end
            S_MIX_B:
            begin
                st_wr_en = 1'b1;
                p_next   = mix_val;
                if (!pass2_reg && left_reg == SW_AW'(1))
                begin
                    pass2_next = 1'b1;
                    left_next  = LAST_POS;
                end
                else
                begin
                    left_next = left_reg - SW_AW'(1);
                end
                if (!pass2_reg)
                    b_next = (b_inc >= len_reg) ? '0 : b_inc[KAW-1:0];
                if (n_reg != LAST_POS)
                    n_next = n_reg + SW_AW'(1);
            end
            S_MIX_WRAP:
            begin
                // word 0 mirrors the last word
                st_wr_en   = 1'b1;
                st_wr_addr = '0;
                st_wr_data = p_reg;
                n_next     = SW_AW'(1);
            end
            S_MIX_END:
            begin
                st_wr_en   = 1'b1;
                st_wr_addr = '0;
                st_wr_data = HIGH_BIT;
            end
            S_TW_START:
            begin
                rd_a_addr = '0;
                n_next    = '0;
            end
            S_TW_LD:
            begin
                cur_next = rd_a_data;
            end
            S_TW_A:
            begin
                rd_a_addr = (n_reg == LAST_POS) ? '0 : n_reg + SW_AW'(1);
                rd_b_addr = (n_reg < FAR_SPLIT) ? n_reg + SW_AW'(SHIFT_M)
                                                : n_reg - FAR_SPLIT;
            end
            S_TW_B:
            begin
                st_wr_en   = 1'b1;
                st_wr_data = mtp_twist(cur_reg, rd_a_data, rd_b_data);
                // the old next word is the current word of the next step
                cur_next   = rd_a_data;
                if (n_reg == LAST_POS)
                    idx_next = '0;
                else
                    n_next = n_reg + SW_AW'(1);
            end
            S_DRAW_RD:
            begin
                rd_a_addr = idx_reg;
            end
            S_DRAW_OUT:
            begin
                rd_a_addr = idx_reg;
                if (out_free)
                begin
                    out_word_next  = mtp_temper(rd_a_data);
                    out_valid_next = 1'b1;
                    idx_next       = idx_reg + SW_AW'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ctx_reg       <= AFTER_NONE;
            seeded_reg    <= 1'b0;
            idx_reg       <= ALL_USED;
            key_count_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ctx_reg       <= ctx_next;
            seeded_reg    <= seeded_next;
            idx_reg       <= idx_next;
            key_count_reg <= key_count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg      <= len_next;
        b_reg        <= b_next;
        n_reg        <= n_next;
        left_reg     <= left_next;
        pass2_reg    <= pass2_next;
        p_reg        <= p_next;
        prod_reg     <= prod_next;
        cur_reg      <= cur_next;
        seed_reg     <= seed_next;
        out_word_reg <= out_word_next;
    end

`ifndef NO_ASSERTIONS
    a_out_from_draw: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DRAW_OUT))
        else $error("result raised outside the draw step");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= ALL_USED)
        else $error("draw index beyond state size");

    a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
        st_wr_en |-> st_wr_addr <= LAST_POS)
        else $error("state write beyond state size");

    a_key_count: assert property (@(posedge clk) disable iff (!rst_n)
        key_count_reg <= KEY_FULL)
        else $error("key count beyond key depth");

    a_draw_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DRAW_OUT && out_free) |=> idx_reg == $past(idx_reg) + SW_AW'(1))
        else $error("draw did not advance the index");
`endif

endmodule

// ----- tb/sv/tb_mersenne_twister_prng.sv -----
// ---------------------------------------------------------------------------
// tb_mersenne_twister_prng
// Self-checking bench for the MT19937 generator.
// ---------------------------------------------------------------------------
// A short table of directed beats comes first. It covers a draw straight out
// of reset, seeds at both extremes, key loads and ignored codes. A key
// overflow run and a random phase follow, with one long draw run that
// crosses twists. A behavioral model of the generator predicts every drawn
// word. Both sides insert random idle cycles.
// ---------------------------------------------------------------------------
module tb_mersenne_twister_prng;
    timeunit 1ns;
    timeprecision 1ps;

    import mtp_pkg::*;

    localparam int          KEY_SLOTS = 16;
    localparam logic [1:0]  MODE_NONE = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  mode;
    logic [31:0] word;
    logic        key_last;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] random_word;

    mersenne_twister_prng #(.KEY_DEPTH(KEY_SLOTS)) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .word        (word),
        .key_last    (key_last),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .random_word (random_word)
    );

    // generator model state
    logic [31:0] gen_words [STATE_WORDS];
    int          gen_pos;
    bit          gen_seeded;
    logic [31:0] gen_keys [KEY_SLOTS];
    int          gen_key_cnt;

    logic [31:0] pending_words [$];
    int          err_cnt;
    int          draw_cnt;
    int          seed_cnt;
    int          mix_cnt;
    bit          quiet;

    typedef struct {
        logic [1:0]  op;
        logic [31:0] data;
        logic        last;
        bit          known;
        logic [31:0] value;
    } dir_row_t;

    function automatic void gen_fill(input logic [31:0] s);
        logic [31:0] p;
        gen_words[0] = s;
        for (int n = 1; n < STATE_WORDS; n++)
        begin
            p = gen_words[n-1];
            gen_words[n] = C_FILL * (p ^ (p >> 30)) + 32'(n);
        end
        gen_pos    = STATE_WORDS;
        gen_seeded = 1'b1;
    endfunction

    function automatic void gen_mix(input int len);
        int          a;
        int          b;
        logic [31:0] p;
        logic [31:0] prod;
        a = 1;
        b = 0;
        gen_fill(MIX_SEED);
        for (int left = (STATE_WORDS > len ? STATE_WORDS : len); left > 0; left--)
        begin
            p    = gen_words[a-1];
            prod = (p ^ (p >> 30)) * C_MIX1;
            gen_words[a] = (gen_words[a] ^ prod) + gen_keys[b] + 32'(b);
            a++;
            b++;
            if (a >= STATE_WORDS)
            begin
                gen_words[0] = gen_words[STATE_WORDS-1];
                a = 1;
            end
            if (b >= len)
                b = 0;
        end
        for (int left = STATE_WORDS - 1; left > 0; left--)
        begin
            p    = gen_words[a-1];
            prod = (p ^ (p >> 30)) * C_MIX2;
            gen_words[a] = (gen_words[a] ^ prod) - 32'(a);
            a++;
            if (a >= STATE_WORDS)
            begin
                gen_words[0] = gen_words[STATE_WORDS-1];
                a = 1;
            end
        end
        gen_words[0] = HIGH_BIT;
    endfunction

    function automatic logic [31:0] gen_draw();
        logic [31:0] y;
        if (gen_pos >= STATE_WORDS)
        begin
            if (!gen_seeded)
                gen_fill(DFLT_SEED);
            for (int n = 0; n < STATE_WORDS; n++)
            begin
                y = (gen_words[n] & HIGH_BIT) | (gen_words[(n + 1) % STATE_WORDS] & LOW_BITS);
                gen_words[n] = gen_words[(n + SHIFT_M) % STATE_WORDS] ^ (y >> 1)
                             ^ (y[0] ? TWIST_A : 32'd0);
            end
            gen_pos = 0;
        end
        y = gen_words[gen_pos];
        gen_pos++;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        return y ^ (y >> 18);
    endfunction

    // update the model for one accepted beat; known overrides the prediction
    function automatic void gen_apply(input logic [1:0] op, input logic [31:0] data,
                                      input logic last, input bit known,
                                      input logic [31:0] value);
        logic [31:0] w;
        case (op)
            MODE_SEED:
            begin
                gen_fill(data);
                seed_cnt++;
            end
            MODE_KEY:
            begin
                if (gen_key_cnt < KEY_SLOTS)
                begin
                    gen_keys[gen_key_cnt] = data;
                    gen_key_cnt++;
                end
                if (last)
                begin
                    gen_mix(gen_key_cnt);
                    gen_key_cnt = 0;
                    mix_cnt++;
                end
            end
            MODE_DRAW:
            begin
                w = gen_draw();
                pending_words.push_back(known ? value : w);
                draw_cnt++;
            end
            default: ;
        endcase
    endfunction

    function automatic int idle_gap();
        return quiet ? 0 : $urandom_range(0, 6);
    endfunction

    task automatic send_beat(input logic [1:0] op, input logic [31:0] data,
                             input logic last, input bit known = 0,
                             input logic [31:0] value = '0);
        int g;
        g = idle_gap();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= op;
        word     <= data;
        key_last <= last;
        do @(posedge clk); while (!in_ready);
        gen_apply(op, data, last, known, value);
    endtask

    task automatic send_key_run(input int len);
        for (int k = 0; k < len; k++)
        begin
            // sometimes reseed in the middle of collection
            if ($urandom_range(0, 15) == 0)
                send_beat(MODE_SEED, $urandom, 1'($urandom));
            send_beat(MODE_KEY, $urandom, k == len - 1);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // result side
    initial
    begin
        int g;
        out_ready = 1'b0;
        forever
        begin
            g = idle_gap();
            if (g > 0)
            begin
                out_ready <= 1'b0;
                repeat (g) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            if (pending_words.size() == 0)
            begin
                $error("random_word: unexpected beat, actual %h", random_word);
                err_cnt++;
            end
            else
            begin
                logic [31:0] exp_w;
                exp_w = pending_words.pop_front();
                if (random_word !== exp_w)
                begin
                    $error("random_word: expected %h, actual %h", exp_w, random_word);
                    err_cnt++;
                end
            end
        end
    end

    initial
    begin
        #100_000_000;
        $display("Timeout with %0d words outstanding", pending_words.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        dir_row_t dir_rows [20];
        int       sent;
        int       r;
        dir_rows = '{
            '{MODE_DRAW, 32'h0,        1'b0, 1, 32'd3499211612},
            '{MODE_DRAW, 32'h0,        1'b0, 0, 32'h0},
            '{MODE_NONE, 32'hffffffff, 1'b1, 0, 32'h0},
            '{MODE_SEED, 32'h0,        1'b0, 0, 32'h0},
            '{MODE_DRAW, 32'hffffffff, 1'b0, 1, 32'd2357136044},
            '{MODE_SEED, 32'd5489,     1'b1, 0, 32'h0},
            '{MODE_DRAW, 32'h0,        1'b0, 1, 32'd3499211612},
            '{MODE_KEY,  32'h123,      1'b0, 0, 32'h0},
            '{MODE_KEY,  32'h234,      1'b0, 0, 32'h0},
            '{MODE_KEY,  32'h345,      1'b0, 0, 32'h0},
            '{MODE_KEY,  32'h456,      1'b1, 0, 32'h0},
            '{MODE_DRAW, 32'h0,        1'b0, 1, 32'd1067595299},
            '{MODE_KEY,  32'hffffffff, 1'b1, 0, 32'h0},
            '{MODE_DRAW, 32'h0,        1'b0, 0, 32'h0},
            '{MODE_SEED, 32'hffffffff, 1'b0, 0, 32'h0},
            '{MODE_DRAW, 32'h0,        1'b1, 0, 32'h0},
            '{MODE_KEY,  32'h0,        1'b0, 0, 32'h0},
            '{MODE_SEED, 32'h1,        1'b0, 0, 32'h0},
            '{MODE_KEY,  32'hffffffff, 1'b1, 0, 32'h0},
            '{MODE_DRAW, 32'h0,        1'b0, 0, 32'h0}
        };
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        mode        = MODE_DRAW;
        word        = '0;
        key_last    = 1'b0;
        err_cnt     = 0;
        draw_cnt    = 0;
        seed_cnt    = 0;
        mix_cnt     = 0;
        quiet       = 0;
        gen_pos     = STATE_WORDS;
        gen_seeded  = 0;
        gen_key_cnt = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_beat(dir_rows[i].op, dir_rows[i].data, dir_rows[i].last,
                      dir_rows[i].known, dir_rows[i].value);

        // overflow the key store; the last words are dropped, but the final beat still starts the mix
        send_key_run(KEY_SLOTS + 3);

        // long draw run across twists, first half with no idling
        send_beat(MODE_SEED, $urandom, 1'b0);
        for (int i = 0; i < 640; i++)
        begin
            quiet = (i < 320);
            send_beat(MODE_DRAW, $urandom, 1'($urandom));
        end
        quiet = 0;

        sent = 0;
        while (sent < 70)
        begin
            r = $urandom_range(0, 99);
            if (r < 4)
            begin
                send_beat(MODE_SEED, $urandom, 1'($urandom));
                sent++;
            end
            else if (r < 9)
            begin
                int len;
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 20)
                                                  : $urandom_range(1, 4);
                send_key_run(len);
                sent += len;
            end
            else if (r < 11)
            begin
                send_beat(MODE_NONE, $urandom, 1'($urandom));
                sent++;
            end
            else
            begin
                if (r > 90)
                    quiet = ~quiet;
                send_beat(MODE_DRAW, $urandom, 1'($urandom));
                sent++;
            end
        end
        in_valid <= 1'b0;

        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Checked %0d draws across %0d seeds and %0d key mixes",
                 draw_cnt, seed_cnt, mix_cnt);
        if (err_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
